FILE: hw/rtl/ipc_pkg.sv
// Shared types and constants for the inversion pair counter.
package ipc_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int CNT_W     = $clog2(MAX_ITEMS);
    localparam int COUNT_W   = 30;

    localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic               overflow;
    } t_out_item;

    // value marching down the cell chain with its partial count
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               stored;
        logic signed [31:0] value;
        logic [CNT_W-1:0]   cnt;
    } t_token;

endpackage

FILE: hw/rtl/ipc_cell.sv
// One chain cell: holds one stored value, compares and forwards a token.
module ipc_cell
    import ipc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_token i_tok,
    output t_token o_tok
);

    logic               r_full;
    logic signed [31:0] r_val;
    t_token             r_tok;
    t_token             n_tok;
    logic               cmp;
    logic               store;

    assign cmp   = r_full && (r_val > i_tok.value);
    assign store = i_tok.valid && !i_tok.stored && !r_full;

    always_comb begin
        n_tok        = i_tok;
        n_tok.cnt    = i_tok.cnt + CNT_W'(cmp);
        n_tok.stored = i_tok.stored | store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            if (i_tok.valid && i_tok.last) begin
                r_full <= 1'b0;
            end else if (store) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && store) begin
            r_val <= i_tok.value;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: hw/rtl/ipc_accum.sv
// End of chain: running count modulo the prime, overflow flag, result register.
module ipc_accum
    import ipc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_token    i_tok,
    input  logic      i_out_stall,
    output logic      o_adv,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [COUNT_W-1:0] r_run;
    logic               r_ovf;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] red;
    logic               ovf;

    assign o_adv = !(r_out_valid && i_out_stall);

    always_comb begin
        sum = {1'b0, r_run} + (i_tok.stored ? (COUNT_W+1)'(i_tok.cnt) : '0);
        if (sum >= {1'b0, COUNT_MOD}) begin
            red = COUNT_W'(sum - {1'b0, COUNT_MOD});
        end else begin
            red = sum[COUNT_W-1:0];
        end
        ovf = r_ovf | !i_tok.stored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= 1'b0;
            if (i_tok.valid) begin
                if (i_tok.last) begin
                    r_run       <= '0;
                    r_ovf       <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_run <= red;
                    r_ovf <= ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_tok.valid && i_tok.last) begin
            r_out.pair_count <= red;
            r_out.overflow   <= ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run < COUNT_MOD) else $error("running count out of range");
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.pair_count < COUNT_MOD) else $error("result out of range");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_adv) else $error("chain moved under stall");
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_valid) else $error("result valid after reset");
`endif

endmodule

FILE: hw/rtl/inversion_pair_counter_core.sv
// Inversion pair counter: systolic chain of compare cells plus result stage.
//
//  channel   dir  signals                       item
//  in        in   i_in_valid / o_in_stall       t_in_item  {value, last}
//  out       out  o_out_valid / i_out_stall     t_out_item {pair_count, overflow}
//
// One item enters per cycle while o_in_stall is low; each value walks the
// MAX_ITEMS-cell chain one cell per cycle while the chain advances, and its
// result is registered in the result stage once its last item leaves the chain.
// Throughput stays one item per cycle while the output does not stall.
// A pending result under output stall freezes the whole chain and stalls input.
// Reset empties every cell at once; the last item empties cells as it passes.
module inversion_pair_counter_core
    import ipc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_token tok [0:MAX_ITEMS];
    logic   adv;

    assign tok[0] = '{valid:  i_in_valid,
                      last:   i_in_item.last,
                      stored: 1'b0,
                      value:  i_in_item.value,
                      cnt:    '0};

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        ipc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1])
        );
    end

    ipc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok[MAX_ITEMS]),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = !adv;

endmodule

FILE: verif/tb_inversion_pair_counter_core.sv
// Self-checking testbench for the inversion pair counter core.
module tb_inversion_pair_counter_core
    import ipc_pkg::*;
();

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_VALUES = 1350;
    localparam int QUIET_TAIL    = 120;
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_CYCLES  = MAX_ITEMS + 20;
    localparam int WATCHDOG      = 2_000_000;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {FULL_RANGE, NEAR_ZERO, EXTREMES, MIXED} t_value_mix;

    class pair_count_board;
        logic signed [31:0] held[MAX_ITEMS];
        int unsigned        fill;
        logic [COUNT_W-1:0] tally;
        bit                 dropped;
        t_out_item          expected_counts[$];
        int unsigned        errors;
        int unsigned        accepted;
        int unsigned        checked;
        int unsigned        overflow_results;

        function void note_value(t_in_item it);
            logic signed [31:0] v;
            longint             sum;
            int unsigned        greater;
            t_out_item          res;
            v = it.value;
            greater = 0;
            accepted++;
            if (fill < MAX_ITEMS) begin
                for (int k = 0; k < fill; k++)
                    if (held[k] > v)
                        greater++;
                sum = longint'(tally) + greater;
                if (sum >= longint'(COUNT_MOD))
                    sum -= longint'(COUNT_MOD);
                tally = sum[COUNT_W-1:0];
                held[fill] = v;
                fill++;
            end else begin
                dropped = 1'b1;
            end
            if (it.last) begin
                res.pair_count = tally;
                res.overflow   = dropped;
                expected_counts.push_back(res);
                fill    = 0;
                tally   = '0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result, pair_count %0d overflow %0b",
                         $time, got.pair_count, got.overflow);
                errors++;
                return;
            end
            want = expected_counts.pop_front();
            checked++;
            if (want.overflow)
                overflow_results++;
            if (got.pair_count !== want.pair_count) begin
                $display("%0t: pair_count mismatch, expected %0d, actual %0d",
                         $time, want.pair_count, got.pair_count);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow mismatch, expected %0b, actual %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    pair_count_board board;
    bit              idle_on;
    bit              long_hold_req;
    int unsigned     sequences_sent;

    inversion_pair_counter_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #HALF_PERIOD clk = ~clk;

    // results belong to earlier items, so check before noting this edge's item
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                board.check_result(out_item);
            if (in_valid && !in_stall)
                board.note_value(in_item);
        end
    end

    initial begin
        out_stall <= 1'b0;
        forever begin
            if (long_hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    function automatic logic signed [31:0] pick_value(input t_value_mix mix);
        logic [31:0] raw;
        t_value_mix  m;
        m = (mix == MIXED) ? t_value_mix'($urandom_range(0, 2)) : mix;
        case (m)
            NEAR_ZERO: raw = $urandom_range(0, 8) - 4;
            EXTREMES: begin
                case ($urandom_range(0, 4))
                    0: raw = VAL_MIN;
                    1: raw = VAL_MAX;
                    2: raw = 32'd0;
                    3: raw = 32'hffff_ffff;
                    default: raw = 32'd1;
                endcase
            end
            default: raw = $urandom();
        endcase
        return raw;
    endfunction

    task automatic offer(input logic signed [31:0] v, input logic l);
        t_in_item it;
        it.value = v;
        it.last  = l;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic send_sequence(input int unsigned len, input t_value_mix mix);
        for (int k = 0; k < len; k++)
            offer(pick_value(mix), k == len - 1);
        sequences_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.expected_counts.size() != 0) @(posedge clk);
    endtask

    initial begin
        #WATCHDOG;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned seq_idx;
        int unsigned len;
        board = new();
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        sequences_sent = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single value, extremes, equal values, strict descent
        offer(VAL_MIN, 1'b1);
        offer(VAL_MAX, 1'b0);
        offer(VAL_MIN, 1'b1);
        offer(VAL_MIN, 1'b0);
        offer(VAL_MAX, 1'b0);
        offer(32'sd0, 1'b0);
        offer(-32'sd1, 1'b1);
        offer(-32'sd1, 1'b0);
        offer(-32'sd1, 1'b0);
        offer(-32'sd1, 1'b1);
        offer(32'sd5, 1'b0);
        offer(32'sd3, 1'b0);
        offer(32'sd3, 1'b0);
        offer(32'sd1, 1'b1);
        offer(VAL_MAX, 1'b0);
        offer(32'sd1, 1'b0);
        offer(32'sd0, 1'b0);
        offer(-32'sd1, 1'b0);
        offer(VAL_MIN, 1'b1);
        sequences_sent += 6;
        wait_drained();

        sent = 0;
        seq_idx = 0;
        while (sent < RANDOM_VALUES) begin
            if (seq_idx == 3)
                long_hold_req = 1'b1;
            if (seq_idx == 9)
                wait_drained();
            if (RANDOM_VALUES - sent < QUIET_TAIL)
                idle_on = 1'b0;
            if (seq_idx == 6)
                len = MAX_ITEMS + 1 + $urandom_range(0, 2);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(41, 120);
            else
                len = $urandom_range(1, 40);
            send_sequence(len, t_value_mix'($urandom_range(0, 3)));
            sent += len;
            seq_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d sequences, %0d values accepted; %0d results checked",
                 sequences_sent, board.accepted, board.checked);
        $display("%0d results carried the overflow flag", board.overflow_results);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
